FILE: sv/dmst_pkg.sv
// Package for the differential motor speed and turn loop.
// Holds the request, result and configuration types, register indexes and
// the fixed arithmetic widths. Depends on nothing.
package dmst_pkg;

  // Width of the speed accumulator, which saturates at this signed range.
  localparam int ACCUM_WIDTH = 32;

  // Encoder count sums hold two 16 bit deltas.
  localparam int CNT_W   = 17;
  // Error terms: a 16 bit target minus a sum of two count sums.
  localparam int ERR_W   = 19;
  // Error times a Q8.8 gain.
  localparam int PROD_W  = 35;
  // Product after the divide by 256.
  localparam int QUO_W   = 27;
  // Working width for accumulator and drive sums.
  localparam int SUM_W   = ((ACCUM_WIDTH > QUO_W) ? ACCUM_WIDTH : QUO_W) + 2;

  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W-ACCUM_WIDTH+1){1'b0}}, {(ACCUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SETPOINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd4;

  localparam logic signed [15:0] SPEED_GAIN_RST  = -16'sd1280;
  localparam logic signed [15:0] TURN_GAIN_RST   = 16'sd2560;
  localparam logic [14:0]        DRIVE_LIMIT_RST = 15'd7666;

  typedef struct packed {
    logic signed [15:0] target_speed;
    logic signed [15:0] turn_setpoint;
    logic signed [15:0] speed_gain;
    logic signed [15:0] turn_gain;
    logic [14:0]        drive_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [15:0] left_count_delta;
    logic signed [15:0] right_count_delta;
    logic               key_click;
  } in_item_t;

  typedef struct packed {
    logic [14:0] left_magnitude;
    logic        left_forward;
    logic [14:0] right_magnitude;
    logic        right_forward;
    logic        stopped;
  } out_item_t;

endpackage

FILE: sv/dmst_cfg.sv
// Configuration register file of the differential motor speed and turn loop.
// Depends on dmst_pkg.
module dmst_cfg
  import dmst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]          cfg_wdata,
  output cfg_regs_t            regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_TARGET_SPEED:  regs_nxt.target_speed  = cfg_wdata;
        REG_TURN_SETPOINT: regs_nxt.turn_setpoint = cfg_wdata;
        REG_SPEED_GAIN:    regs_nxt.speed_gain    = cfg_wdata;
        REG_TURN_GAIN:     regs_nxt.turn_gain     = cfg_wdata;
        REG_DRIVE_LIMIT:   regs_nxt.drive_limit   = cfg_wdata[14:0];
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.target_speed  <= '0;
      regs_r.turn_setpoint <= '0;
      regs_r.speed_gain    <= SPEED_GAIN_RST;
      regs_r.turn_gain     <= TURN_GAIN_RST;
      regs_r.drive_limit   <= DRIVE_LIMIT_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

FILE: sv/dmst_core.sv
// Control state and single-pass step logic of the speed and turn loop.
// Depends on dmst_pkg.
module dmst_core
  import dmst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output logic      res_valid,
  output out_item_t res
);

  logic                          phase_r, phase_nxt;
  logic                          halted_r, halted_nxt;
  logic signed [CNT_W-1:0]       lsum_r, lsum_nxt, rsum_r, rsum_nxt;
  logic signed [ACCUM_WIDTH-1:0] acc_r, acc_nxt;

  logic signed [CNT_W-1:0]       lsum_new, rsum_new;
  logic signed [ERR_W-1:0]       speed_err, turn_err;
  logic signed [PROD_W-1:0]      speed_prod, turn_prod;
  logic signed [PROD_W-1:0]      speed_adj, turn_adj;
  logic signed [QUO_W-1:0]       speed_quo, turn_quo;
  logic signed [SUM_W-1:0]       acc_sum, acc_sat, left_raw, right_raw;
  logic signed [SUM_W-1:0]       lim_pos, lim_neg, left_drv, right_drv;
  logic                          step;

  // Truncation toward zero: bias negative products before the shift.
  function automatic logic signed [QUO_W-1:0] div256(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] b;
    b = p + (p[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
    return QUO_W'(b >>> 8);
  endfunction

  function automatic logic signed [SUM_W-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                                    input logic signed [SUM_W-1:0] hi,
                                                    input logic signed [SUM_W-1:0] lo);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (c > hi) c = hi;
    if (c < lo) c = lo;
    return c;
  endfunction

  always_comb begin
    lsum_new   = lsum_r + CNT_W'(item.left_count_delta);
    rsum_new   = rsum_r + CNT_W'(item.right_count_delta);
    step       = phase_r;  // phase flips back to zero on this request

    speed_err  = ERR_W'(cfg.target_speed) - ERR_W'(lsum_new) - ERR_W'(rsum_new);
    turn_err   = ERR_W'(cfg.turn_setpoint) - ERR_W'(lsum_new) + ERR_W'(rsum_new);
    speed_prod = PROD_W'(speed_err) * PROD_W'(cfg.speed_gain);
    turn_prod  = PROD_W'(turn_err) * PROD_W'(cfg.turn_gain);
    speed_adj  = speed_prod;
    turn_adj   = turn_prod;
    speed_quo  = div256(speed_adj);
    turn_quo   = div256(turn_adj);

    // The increment is the negated quotient.
    acc_sum    = SUM_W'(acc_r) - SUM_W'(speed_quo);
    acc_sat    = clamp(acc_sum, ACC_MAX, ACC_MIN);

    lim_pos    = SUM_W'({1'b0, cfg.drive_limit});
    lim_neg    = -lim_pos;
    left_raw   = acc_sat + SUM_W'(turn_quo);
    right_raw  = acc_sat - SUM_W'(turn_quo);
    halted_nxt = halted_r ^ (fire & item.key_click);
    left_drv   = halted_nxt ? '0 : clamp(left_raw, lim_pos, lim_neg);
    right_drv  = halted_nxt ? '0 : clamp(right_raw, lim_pos, lim_neg);

    res.left_magnitude  = left_drv[SUM_W-1] ? 15'(-left_drv) : left_drv[14:0];
    res.left_forward    = (left_drv > 0);
    res.right_magnitude = right_drv[SUM_W-1] ? 15'(-right_drv) : right_drv[14:0];
    res.right_forward   = (right_drv > 0);
    res.stopped         = halted_nxt;
    res_valid           = fire & step;

    phase_nxt = phase_r;
    lsum_nxt  = lsum_r;
    rsum_nxt  = rsum_r;
    acc_nxt   = acc_r;
    if (fire) begin
      phase_nxt = ~phase_r;
      if (step) begin
        lsum_nxt = '0;
        rsum_nxt = '0;
        acc_nxt  = halted_nxt ? '0 : ACCUM_WIDTH'(acc_sat);
      end else begin
        lsum_nxt = lsum_new;
        rsum_nxt = rsum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      halted_r <= 1'b1;
      lsum_r   <= '0;
      rsum_r   <= '0;
      acc_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      halted_r <= halted_nxt;
      lsum_r   <= lsum_nxt;
      rsum_r   <= rsum_nxt;
      acc_r    <= acc_nxt;
    end
  end

endmodule

FILE: sv/differential_motor_speed_turn_loop_unit.sv
// Top level of the differential motor speed and turn loop.
// Depends on dmst_pkg, dmst_cfg and dmst_core.
//
// Usage: each request on the in_ channel is one control tick carrying the
// left and right encoder deltas and a key-click bit. A click toggles between
// run and stop. Every second request runs the control step on the summed
// counts and produces one result on the out_ channel: a magnitude and a
// forward bit per motor, plus the stopped flag. The other requests produce
// no result. Registers are written through cfg_we, cfg_idx and cfg_wdata;
// the user must write them only while the block is idle; the block has no
// check for it. Timing: a request is captured in an input register; once
// the result register is free or being emptied, the step logic (one
// multiply per loop, accumulate, clamp) runs and writes the result register.
// One request is taken every cycle while the receiver does not stall.
// Reset (synchronous, rst_n low) clears both registers' valid flags, the
// count sums and the accumulator, sets the stop state and loads the register
// defaults. When the receiver stalls, the result register holds its value;
// the input register then fills and in_stall rises until the result is taken.
module differential_motor_speed_turn_loop_unit
  import dmst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]          cfg_wdata
);

  cfg_regs_t regs;
  in_item_t  item_r;
  logic      item_valid_r, item_valid_nxt;
  out_item_t res, out_r;
  logic      out_valid_r, out_valid_nxt;
  logic      res_valid;
  logic      advance;
  logic      accept;

  dmst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  // The held request moves on whenever the result register is free or is
  // being emptied in this cycle.
  assign advance = item_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = item_valid_r & ~advance;
  assign accept   = in_valid & ~in_stall;

  dmst_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (item_r),
    .cfg       (regs),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (accept) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
